@@ hdl/dq_pkg.sv @@
// Package for the double-ended queue: operation and status codes, the
// controller state type and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEFAULT       = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REVERSE    = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_RESP
  } dq_state_t;

  typedef struct packed {
    logic load;   // capture the operation
    logic exec;   // apply the operation to pointers and storage
    logic done;   // result is on the output ports
  } dq_cmd_t;

endpackage

`default_nettype wire

@@ hdl/dq_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ hdl/dq_ctrl.sv @@
// Controller for the double-ended queue: sequences accept, execute,
// storage read and result strobe. Depends on dq_pkg.
`default_nettype none

module dq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  output dq_pkg::dq_cmd_t      cmd
);

  import dq_pkg::*;

  dq_state_t state;
  dq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        cmd.done   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/dq_datapath.sv @@
// Datapath for the double-ended queue: ring pointers, count, direction
// flag and entry storage. Depends on dq_pkg and dq_ram.
`default_nettype none

module dq_datapath #(
  parameter int DEPTH       = dq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = dq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dq_pkg::dq_cmd_t               cmd,
  input  wire logic [dq_pkg::MODE_W-1:0]     mode,
  input  wire logic [VALUE_WIDTH-1:0]        value,
  output logic      [VALUE_WIDTH-1:0]        front_value,
  output logic      [VALUE_WIDTH-1:0]        back_value,
  output logic      [$clog2(DEPTH+1)-1:0]    count,
  output logic                               is_empty,
  output logic      [dq_pkg::STATUS_W-1:0]   status
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  // Latched operation
  logic [MODE_W-1:0]      op_mode;
  logic [VALUE_WIDTH-1:0] op_value;

  // Queue state
  logic [AW-1:0]          head;
  logic [AW-1:0]          head_next;
  logic [CW-1:0]          count_next;
  logic                   rev;
  logic                   rev_next;
  logic [STATUS_W-1:0]    status_next;

  // Storage access
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          tail;
  logic [VALUE_WIDTH-1:0] rdata_lo;
  logic [VALUE_WIDTH-1:0] rdata_hi;

  logic                   full;
  logic                   empty;
  logic [AW-1:0]          head_dec;
  logic [AW-1:0]          head_inc;
  logic [SW-1:0]          end_sum;
  logic [SW-1:0]          tail_sum;
  logic [AW-1:0]          end_slot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= mode;
      op_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status <= status_next;
    end
  end

  // Ring arithmetic; head + count stays below twice the depth.
  always_comb begin
    full     = (count == CW'(DEPTH));
    empty    = (count == '0);
    head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
    head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
    end_sum  = SW'(head) + SW'(count);
    end_slot = (end_sum >= SW'(DEPTH)) ? AW'(end_sum - SW'(DEPTH)) : AW'(end_sum);
    tail_sum = empty ? SW'(head) : end_sum - 1'b1;
    tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  end

  always_comb begin
    head_next   = head;
    count_next  = count;
    rev_next    = rev;
    status_next = STATUS_DONE;
    we          = 1'b0;
    waddr       = end_slot;
    unique case (op_mode) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          we         = cmd.exec;
          count_next = count + 1'b1;
          if ((op_mode == MODE_PUSH_FRONT) != rev) begin
            head_next = head_dec;
            waddr     = head_dec;
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          count_next = count - 1'b1;
          if ((op_mode == MODE_POP_FRONT) != rev) begin
            head_next = head_inc;
          end
        end
      end
      MODE_REVERSE: begin
        rev_next = ~rev;
      end
      default: begin
      end
    endcase
  end

  // Reads follow the updated pointers in the cycle after the write.
  dq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (op_value),
    .raddr_a (head),
    .raddr_b (tail),
    .rdata_a (rdata_lo),
    .rdata_b (rdata_hi)
  );

  always_comb begin
    is_empty    = empty;
    front_value = '0;
    back_value  = '0;
    if (!empty) begin
      front_value = rev ? rdata_hi : rdata_lo;
      back_value  = rev ? rdata_lo : rdata_hi;
    end
  end

endmodule

`default_nettype wire

@@ hdl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue: controller plus datapath.
// Depends on dq_pkg, dq_ctrl, dq_datapath (and dq_ram below it).
//
// Usage:
//   Command channel: drive mode and value and raise start. The command is
//   taken at a rising edge where start is high and busy is low; mode and
//   value need only be valid at that edge.
//   Modes: push front, push back, pop front, pop back, reverse. Reverse
//   flips a direction flag so front and back trade physical ends of the
//   ring; no data moves. Unused mode codes leave the queue as it is.
//   Result channel: every command yields one result transfer, shown for
//   exactly one cycle with done high: front_value, back_value, count,
//   is_empty and status. front_value/back_value are zero when empty.
//   A push while full or a pop while empty changes nothing and reports
//   a refused status.
//   Timing: done rises after the execute and storage-read states; busy
//   is high from the accepting edge until done has dropped, so no new
//   command is taken before the last result. The storage RAM sets this:
//   a push is written at execute, the registered read of both ends follows.
//   Reset (rst, synchronous) empties the queue and clears the direction
//   flag; stored words are not cleared and are never read before written.
//   The receiver cannot stall: a result not taken in its cycle is gone.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH       = dq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = dq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [dq_pkg::MODE_W-1:0]     mode,
  input  wire logic [VALUE_WIDTH-1:0]        value,
  output logic                               done,
  output logic      [VALUE_WIDTH-1:0]        front_value,
  output logic      [VALUE_WIDTH-1:0]        back_value,
  output logic      [$clog2(DEPTH+1)-1:0]    count,
  output logic                               is_empty,
  output logic      [dq_pkg::STATUS_W-1:0]   status
);

  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  dq_cmd_t cmd;

  // Sequencer: idle -> execute -> storage read -> result
  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Ring pointers, count, direction flag and storage
  dq_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .value       (value),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .is_empty    (is_empty),
    .status      (status)
  );

  assign done = cmd.done;

  // Accepted command is followed by its result once the execute and read states have passed.
  a_result_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result did not follow accepted command");

  // No new command while one is in flight.
  a_busy_while_working : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // Empty flag agrees with count, and an empty queue reports zero values.
  a_empty_values : assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (count == '0 && front_value == '0 && back_value == '0))
    else $error("empty queue reported data");

  // A refused push only happens at capacity.
  a_full_refusal : assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_FULL) |-> (count == CW'(DEPTH)))
    else $error("push refused below capacity");

  // A refused pop only happens when empty.
  a_empty_refusal : assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_EMPTY) |-> is_empty)
    else $error("pop refused on non-empty queue");

endmodule

`default_nettype wire

@@ tb/dq_checker.sv @@
// Checker for the double-ended queue: watches command and result transfers,
// predicts each result from its own queue model and compares field by field.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_checker #(
  parameter int DEPTH       = dq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = dq_pkg::VALUE_WIDTH_DEFAULT,
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [dq_pkg::MODE_W-1:0]     mode,
  input  wire logic [VALUE_WIDTH-1:0]        value,
  input  wire logic                          done,
  input  wire logic [VALUE_WIDTH-1:0]        front_value,
  input  wire logic [VALUE_WIDTH-1:0]        back_value,
  input  wire logic [CNT_W-1:0]              count,
  input  wire logic                          is_empty,
  input  wire logic [dq_pkg::STATUS_W-1:0]   status,
  output int                                 errors,
  output int                                 pending
);

  import dq_pkg::*;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] front;
    logic [VALUE_WIDTH-1:0] back;
    logic [CNT_W-1:0]       fill;
    logic                   empty;
    logic [STATUS_W-1:0]    stat;
  } queue_view_t;

  // model of the ring: live words sit at first_slot .. first_slot+occupancy-1
  logic [VALUE_WIDTH-1:0] ring_model [DEPTH];
  int                     first_slot;
  int                     occupancy;
  logic                   flipped;

  queue_view_t pending_views[$];
  int          mismatches = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // apply one operation to the model and return what the block must show
  task automatic apply_queue_op(input logic [MODE_W-1:0] op,
                                input logic [VALUE_WIDTH-1:0] word,
                                output queue_view_t view);
    logic is_full;
    logic at_first;
    view      = '0;
    view.stat = STATUS_DONE;
    is_full   = occupancy >= DEPTH;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        // front is the low physical end unless the direction is flipped
        at_first = (op == MODE_PUSH_FRONT) != flipped;
        if (is_full) begin
          view.stat = STATUS_FULL;
        end else if (at_first) begin
          first_slot             = (first_slot + DEPTH - 1) % DEPTH;
          ring_model[first_slot] = word;
          occupancy++;
        end else begin
          ring_model[(first_slot + occupancy) % DEPTH] = word;
          occupancy++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        at_first = (op == MODE_POP_FRONT) != flipped;
        if (occupancy == 0) begin
          view.stat = STATUS_EMPTY;
        end else if (at_first) begin
          first_slot = (first_slot + 1) % DEPTH;
          occupancy--;
        end else begin
          occupancy--;
        end
      end
      MODE_REVERSE: begin
        flipped = !flipped;
      end
      default: begin
      end
    endcase
    if (occupancy != 0) begin
      view.front = flipped ? ring_model[(first_slot + occupancy - 1) % DEPTH]
                           : ring_model[first_slot];
      view.back  = flipped ? ring_model[first_slot]
                           : ring_model[(first_slot + occupancy - 1) % DEPTH];
    end
    view.fill  = CNT_W'(occupancy);
    view.empty = occupancy == 0;
  endtask

  always @(posedge clk) begin
    queue_view_t want;
    queue_view_t next_view;
    if (rst) begin
      first_slot = 0;
      occupancy  = 0;
      flipped    = 1'b0;
      pending_views.delete();
    end else begin
      if (done) begin
        if (pending_views.size() == 0) begin
          report_mismatch("result transfer with none pending", 64'(status), '0);
        end else begin
          want = pending_views.pop_front();
          if (front_value !== want.front)
            report_mismatch("front_value", 64'(front_value), 64'(want.front));
          if (back_value !== want.back)
            report_mismatch("back_value", 64'(back_value), 64'(want.back));
          if (count !== want.fill)
            report_mismatch("count", 64'(count), 64'(want.fill));
          if (is_empty !== want.empty)
            report_mismatch("is_empty", 64'(is_empty), 64'(want.empty));
          if (status !== want.stat)
            report_mismatch("status", 64'(status), 64'(want.stat));
        end
      end
      if (start && !busy) begin
        apply_queue_op(mode, value, next_view);
        pending_views.push_back(next_view);
      end
    end
    pending <= pending_views.size();
    errors  <= mismatches;
  end

endmodule

@@ tb/double_ended_queue_tb.sv @@
// Testbench top for double_ended_queue: clock, reset, command stimulus,
// watchdog and verdict. Depends on dq_pkg, dq_checker and the block's RTL.
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int VW    = VALUE_WIDTH_DEFAULT;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // a command runs through execute, read and result states and sender gaps
  // are short random runs, so a quiet stretch far past both means a hang
  localparam int STALL_LIMIT  = 200;
  // margin after the last result so that a stray result is still seen
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 375;
  localparam int BIAS_RUN        = 25;

  logic                clk   = 1'b0;
  logic                rst   = 1'b1;
  logic                start = 1'b0;
  logic [MODE_W-1:0]   mode  = MODE_PUSH_FRONT;
  logic [VW-1:0]       value = '0;
  logic                busy;
  logic                done;
  logic [VW-1:0]       front_value;
  logic [VW-1:0]       back_value;
  logic [CNT_W-1:0]    count;
  logic                is_empty;
  logic [STATUS_W-1:0] status;

  int errors;
  int pending;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;

  // sender idle percentage per phase; the receiver cannot stall, so the
  // phases meant for receiver stalls run without sender gaps
  int idle_by_phase [4] = '{0, 78, 0, 38};
  // share of queue ops that are pushes, varied so the fill level wanders
  // between empty and full
  int push_bias [3] = '{15, 50, 85};

  always #6 clk = ~clk;

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .value      (value),
    .done       (done),
    .front_value(front_value),
    .back_value (back_value),
    .count      (count),
    .is_empty   (is_empty),
    .status     (status)
  );

  dq_checker #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VW)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .value      (value),
    .done       (done),
    .front_value(front_value),
    .back_value (back_value),
    .count      (count),
    .is_empty   (is_empty),
    .status     (status),
    .errors     (errors),
    .pending    (pending)
  );

  // data words: mostly random, with the all-zero and all-one words mixed in
  function automatic logic [VW-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return VW'($urandom);
    endcase
  endfunction

  // Present one command and hold it until the transfer. Called at a rising
  // edge; returns at the edge that took the command. Before presenting, the
  // sender idles each cycle with the phase's idle percentage; otherwise
  // start stays high into the next command.
  task automatic send_cmd(input logic [MODE_W-1:0] op, input logic [VW-1:0] word);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode  <= op;
    value <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // watchdog: any command or result transfer counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL double_ended_queue");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                roll;
    int                push_pct;
    logic [MODE_W-1:0] op;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: refused pops on the empty queue, reverse while empty,
    // the unused mode codes, pushes and pops with the direction flipped,
    // then fill to the brim and try pushing at both ends
    send_cmd(MODE_POP_FRONT, '1);
    send_cmd(MODE_POP_BACK, '0);
    send_cmd(MODE_REVERSE, '1);
    for (int c = int'(MODE_REVERSE) + 1; c < (1 << MODE_W); c++) begin
      send_cmd(MODE_W'(c), rand_word());
    end
    send_cmd(MODE_PUSH_FRONT, '0);
    send_cmd(MODE_PUSH_BACK, '1);
    send_cmd(MODE_POP_FRONT, '0);
    send_cmd(MODE_REVERSE, '0);
    for (int k = 1; k < DEPTH; k++) begin
      send_cmd(k[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, rand_word());
    end
    send_cmd(MODE_PUSH_FRONT, rand_word());
    send_cmd(MODE_PUSH_BACK, rand_word());

    // random: mostly pushes and pops, some reverses, a few unused codes
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_by_phase[phase];
      push_pct        = push_bias[1];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % BIAS_RUN == 0) push_pct = push_bias[$urandom_range(2)];
        roll = $urandom_range(99);
        if (roll < 3) begin
          op = MODE_W'($urandom_range((1 << MODE_W) - 1, int'(MODE_REVERSE) + 1));
        end else if (roll < 10) begin
          op = MODE_REVERSE;
        end else if ($urandom_range(99) < push_pct) begin
          op = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        end else begin
          op = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
        end
        send_cmd(op, rand_word());
      end
    end

    // with busy now high, lowering start here loses nothing
    @(posedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

endmodule
